/* rtl/jss_pkg.sv */
`default_nettype none
package jss_pkg;

  localparam int MAX_SCAN_BITS = 64;
  localparam int DATA_W = 64;
  localparam int CNT_W = 7;
  localparam int KIND_W = 3;
  localparam int POS_W = $clog2(MAX_SCAN_BITS);

  // request codes
  localparam logic [2:0] REQ_TAP_RESET = 3'd0;
  localparam logic [2:0] REQ_IR_SCAN = 3'd1;
  localparam logic [2:0] REQ_DR_SCAN = 3'd2;
  localparam logic [2:0] REQ_RUN = 3'd3;
  localparam logic [2:0] REQ_TICK = 3'd4;

  // sequence state codes
  localparam logic [KIND_W-1:0] KIND_IDLE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESET = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IR = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RUN = 3'd4;

  localparam logic [CNT_W:0] RESET_HIGH_CYCLES = 8'd5;
  localparam logic [CNT_W-1:0] SCAN_MAX = CNT_W'(MAX_SCAN_BITS);

  typedef struct packed {
    logic [2:0]        req_type;
    logic [CNT_W-1:0]  bit_count;
    logic [DATA_W-1:0] shift_data;
    logic              tdo;
  } cmd_t;

  typedef struct packed {
    logic              tck_pulse;
    logic              tms;
    logic              tdi;
    logic              done_res;
    logic [DATA_W-1:0] captured_data;
    logic              rejected;
  } res_t;

endpackage
`default_nettype wire

/* rtl/jtag_scan_sequencer_top.sv */
// JTAG scan sequencer: drives a TAP, one TCK pulse per tick beat.
// Command channel (cmd_valid / cmd_stall / cmd): tap reset, instruction
// scan, data scan or run clocks (a nonzero count) load a sequence while
// idle; a command arriving while a sequence runs comes back with rejected
// set. Each tick beat carries the TDO level of its cycle and yields one
// result with the TCK pulse flag and the TMS and TDI levels to drive.
// Result channel (res_valid / res_stall / res): exactly one result beat per
// command beat, in order. done_res marks the last TCK cycle of a command,
// and captured_data holds the TDO bits of a data scan on that beat.
// A command beat taken lands in the input register, and its result moves
// into the result register once that register frees up. Throughput: one
// beat per cycle while res_stall is low, set by the update of the sequence
// state between the two registers.
// Reset (rst, synchronous) returns the sequencer to idle with TMS and TDI
// held low and empties both registers.
// When res_stall is high the result register holds its beat, and cmd_stall
// rises once the input register is also occupied.
`default_nettype none
module jtag_scan_sequencer_top
  import jss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  logic advance;
  logic valid_q;
  cmd_t cmd_q;
  res_t res_d;

  jss_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .advance   (advance),
    .valid_q   (valid_q),
    .cmd_q     (cmd_q)
  );

  jss_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (valid_q && advance),
    .cmd  (cmd_q),
    .res  (res_d)
  );

  jss_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .valid_d   (valid_q),
    .res_d     (res_d),
    .advance   (advance),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

/* rtl/jss_in_reg.sv */
`default_nettype none
module jss_in_reg
  import jss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  input  wire logic advance,
  output logic      valid_q,
  output cmd_t      cmd_q
);

  assign cmd_stall = valid_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (!cmd_stall) begin
      valid_q <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      cmd_q <= cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/jss_core.sv */
`default_nettype none
module jss_core
  import jss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic fire,
  input  wire cmd_t cmd,
  output res_t      res
);

  logic [KIND_W-1:0] active_kind, active_kind_next;
  logic [CNT_W-1:0]  cycle_index, cycle_index_next;
  logic [CNT_W-1:0]  length_in_use, length_in_use_next;
  logic [DATA_W-1:0] out_shift, out_shift_next;
  logic [DATA_W-1:0] capture_shift, capture_shift_next;
  logic              tms_level, tms_level_next;
  logic              tdi_level, tdi_level_next;

  logic [CNT_W-1:0] scan_len;
  logic [CNT_W:0]   idx_w, len_w, pre_w, total, idx_inc, pos_w;
  logic             done;

  always_comb begin
    if (cmd.bit_count == '0) begin
      scan_len = CNT_W'(1);
    end else if (cmd.bit_count > SCAN_MAX) begin
      scan_len = SCAN_MAX;
    end else begin
      scan_len = cmd.bit_count;
    end
  end

  always_comb begin
    active_kind_next   = active_kind;
    cycle_index_next   = cycle_index;
    length_in_use_next = length_in_use;
    out_shift_next     = out_shift;
    capture_shift_next = capture_shift;
    tms_level_next     = tms_level;
    tdi_level_next     = tdi_level;
    res                = '0;
    idx_w   = {1'b0, cycle_index};
    len_w   = {1'b0, length_in_use};
    pre_w   = (active_kind == KIND_IR) ? (CNT_W+1)'(4) : (CNT_W+1)'(3);
    pos_w   = idx_w - pre_w;
    idx_inc = idx_w + (CNT_W+1)'(1);
    total   = '0;
    done    = 1'b0;

    if (cmd.req_type < REQ_TICK) begin
      if (active_kind != KIND_IDLE) begin
        res.rejected = 1'b1;
      end else if (!(cmd.req_type == REQ_RUN && cmd.bit_count == '0)) begin
        active_kind_next = cmd.req_type + KIND_W'(1);
        cycle_index_next = '0;
        priority if (cmd.req_type == REQ_RUN) begin
          length_in_use_next = cmd.bit_count;
        end else if (cmd.req_type == REQ_TAP_RESET) begin
          length_in_use_next = '0;
        end else begin
          length_in_use_next = scan_len;
        end
        out_shift_next     = cmd.shift_data;
        capture_shift_next = '0;
      end
    end else if (cmd.req_type == REQ_TICK && active_kind != KIND_IDLE) begin
      priority if (active_kind == KIND_RESET) begin
        total          = RESET_HIGH_CYCLES + (CNT_W+1)'(1);
        tms_level_next = (idx_w < RESET_HIGH_CYCLES);
      end else if (active_kind == KIND_RUN) begin
        total = len_w;
      end else begin
        total = pre_w + len_w + (CNT_W+1)'(2);
        priority if (idx_w < pre_w) begin
          tms_level_next = (idx_w == '0) ||
                           (active_kind == KIND_IR && idx_w == (CNT_W+1)'(1));
        end else if (idx_w < pre_w + len_w) begin
          tdi_level_next = out_shift[0];
          out_shift_next = out_shift >> 1;
          tms_level_next = (pos_w == len_w - (CNT_W+1)'(1));
          if (active_kind == KIND_DR) begin
            capture_shift_next[pos_w[POS_W-1:0]] = cmd.tdo;
          end
        end else begin
          tms_level_next = (idx_w == pre_w + len_w);
        end
      end
      done             = (idx_inc >= total);
      res.tck_pulse    = 1'b1;
      res.done_res     = done;
      cycle_index_next = idx_inc[CNT_W-1:0];
      if (done) begin
        if (active_kind == KIND_DR) begin
          res.captured_data = capture_shift_next;
        end
        active_kind_next = KIND_IDLE;
        cycle_index_next = '0;
      end
    end
    res.tms = tms_level_next;
    res.tdi = tdi_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_kind   <= KIND_IDLE;
      cycle_index   <= '0;
      length_in_use <= '0;
      out_shift     <= '0;
      capture_shift <= '0;
      tms_level     <= 1'b0;
      tdi_level     <= 1'b0;
    end else if (fire) begin
      active_kind   <= active_kind_next;
      cycle_index   <= cycle_index_next;
      length_in_use <= length_in_use_next;
      out_shift     <= out_shift_next;
      capture_shift <= capture_shift_next;
      tms_level     <= tms_level_next;
      tdi_level     <= tdi_level_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/jss_out_reg.sv */
`default_nettype none
module jss_out_reg
  import jss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic valid_d,
  input  wire res_t res_d,
  output logic      advance,
  output logic      res_valid,
  input  wire logic res_stall,
  output res_t      res
);

  // result register frees up when empty or when its beat is taken
  assign advance = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= valid_d;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && valid_d) begin
      res <= res_d;
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  import jss_pkg::*;

  localparam logic [2:0] REQ_UNDEFINED = 3'd7;
  localparam int N_ITEMS = 650;
  localparam int LONG_HOLD = 60;

  typedef struct {
    cmd_t c;
    res_t want;
    bit   wait_idle;
  } queued_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  jtag_scan_sequencer_top i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tap sequencer state as the testbench tracks it
  logic [2:0]  seq_kind = KIND_IDLE;
  int          seq_idx = 0;
  int          seq_len = 0;
  logic [63:0] out_bits = '0;
  logic [63:0] cap_bits = '0;
  logic        tms_q = 1'b0;
  logic        tdi_q = 1'b0;

  queued_cmd_t cmd_queue[$];
  res_t        pin_results_due[$];
  int          n_queued = 0;
  int          errors = 0;
  int          n_checked = 0;
  int          n_tck = 0;
  int          n_done = 0;
  int          n_rej = 0;

  function automatic res_t tap_cycle_predict(input cmd_t c);
    res_t r;
    int   n;
    int   pre;
    int   total;
    int   pos;
    r = '0;
    if (c.req_type <= REQ_RUN) begin
      if (seq_kind != KIND_IDLE) begin
        r.rejected = 1'b1;
      end else if (!(c.req_type == REQ_RUN && c.bit_count == 0)) begin
        case (c.req_type)
          REQ_TAP_RESET: seq_kind = KIND_RESET;
          REQ_IR_SCAN:   seq_kind = KIND_IR;
          REQ_DR_SCAN:   seq_kind = KIND_DR;
          default:       seq_kind = KIND_RUN;
        endcase
        n = c.bit_count;
        if (n == 0) n = 1;
        if (n > MAX_SCAN_BITS) n = MAX_SCAN_BITS;
        seq_idx = 0;
        seq_len = (c.req_type == REQ_RUN) ? int'(c.bit_count) :
                  (c.req_type == REQ_TAP_RESET) ? 0 : n;
        out_bits = c.shift_data;
        cap_bits = '0;
      end
    end else if (c.req_type == REQ_TICK && seq_kind != KIND_IDLE) begin
      r.tck_pulse = 1'b1;
      if (seq_kind == KIND_RESET) begin
        total = int'(RESET_HIGH_CYCLES) + 1;
        tms_q = (seq_idx < int'(RESET_HIGH_CYCLES));
      end else if (seq_kind == KIND_RUN) begin
        total = seq_len;
      end else begin
        pre = (seq_kind == KIND_IR) ? 4 : 3;
        total = pre + seq_len + 2;
        if (seq_idx < pre) begin
          tms_q = (seq_idx == 0 || (pre == 4 && seq_idx == 1));
        end else if (seq_idx < pre + seq_len) begin
          pos = seq_idx - pre;
          tdi_q = out_bits[0];
          out_bits = out_bits >> 1;
          tms_q = (pos == seq_len - 1);
          if (seq_kind == KIND_DR) cap_bits[pos] = c.tdo;
        end else begin
          tms_q = (seq_idx == pre + seq_len);
        end
      end
      seq_idx++;
      if (seq_idx >= total) begin
        r.done_res = 1'b1;
        if (seq_kind == KIND_DR) r.captured_data = cap_bits;
        seq_kind = KIND_IDLE;
        seq_idx = 0;
      end
    end
    r.tms = tms_q;
    r.tdi = tdi_q;
    return r;
  endfunction

  task automatic queue_cmd(input logic [2:0] req, input logic [6:0] cnt,
                           input logic [63:0] data, input bit hold);
    queued_cmd_t p;
    p.c.req_type = req;
    p.c.bit_count = cnt;
    p.c.shift_data = data;
    p.c.tdo = 1'($urandom_range(0, 1));
    p.want = tap_cycle_predict(p.c);
    p.wait_idle = hold;
    cmd_queue.push_back(p);
    n_queued++;
  endtask

  task automatic queue_tick();
    queue_cmd(REQ_TICK, 7'($urandom), {$urandom, $urandom}, 1'b0);
  endtask

  // mostly short scans, now and then the full width or an oversized count
  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'(MAX_SCAN_BITS);
    if (r == 2) return 7'($urandom_range(MAX_SCAN_BITS + 1, 127));
    if (r == 3) return 7'($urandom_range(13, MAX_SCAN_BITS - 1));
    return 7'($urandom_range(1, 12));
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // command driver
  queued_cmd_t on_wire;
  int          burst_left = 0;
  int          gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (cmd_valid && !cmd_stall) pin_results_due.push_back(on_wire.want);
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_queue.size() == 0 ||
                     (cmd_queue[0].wait_idle && pin_results_due.size() != 0)) begin
          cmd_valid <= 1'b0;
        end else begin
          on_wire = cmd_queue.pop_front();
          cmd <= on_wire.c;
          cmd_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // result checker
  res_t want_r;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pin_results_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, got %0h", $time, res);
      end else begin
        want_r = pin_results_due.pop_front();
        check_field("tck_pulse", 64'(want_r.tck_pulse), 64'(res.tck_pulse));
        check_field("tms", 64'(want_r.tms), 64'(res.tms));
        check_field("tdi", 64'(want_r.tdi), 64'(res.tdi));
        check_field("done_res", 64'(want_r.done_res), 64'(res.done_res));
        check_field("captured_data", want_r.captured_data, res.captured_data);
        check_field("rejected", 64'(want_r.rejected), 64'(res.rejected));
        n_checked++;
        n_tck += want_r.tck_pulse;
        n_done += want_r.done_res;
        n_rej += want_r.rejected;
      end
    end
  end

  // result stall pattern, with one long hold partway through
  int rx_beats = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) rx_beats++;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (!long_hold_done && rx_beats >= 150) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        res_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 40);
        end
        mode_left--;
        case (stall_mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 3) == 0);
          2: res_stall <= ($urandom_range(0, 3) != 0);
          default: res_stall <= ~res_stall;
        endcase
      end
    end
  end

  initial begin
    int         roll;
    logic [2:0] req;
    bit         first_seq;

    // directed: idle and undefined requests, a tap reset, an IR scan with a DR scan rejected mid scan, a run
    queue_tick();
    queue_cmd(REQ_UNDEFINED, 7'h7f, '1, 1'b0);
    queue_cmd(REQ_RUN, 7'd0, '1, 1'b0);
    queue_cmd(REQ_TAP_RESET, 7'h7f, '1, 1'b0);
    while (seq_kind != KIND_IDLE) queue_tick();
    queue_cmd(REQ_IR_SCAN, 7'd0, '1, 1'b0);
    queue_tick();
    queue_cmd(REQ_DR_SCAN, 7'd8, '1, 1'b0);  // arrives mid scan
    while (seq_kind != KIND_IDLE) queue_tick();
    queue_cmd(REQ_RUN, 7'd1, '0, 1'b0);
    queue_tick();
    queue_tick();

    // random: mostly complete sequences, with noise mixed in
    first_seq = 1'b1;
    while (n_queued < N_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_cmd(3'($urandom_range(int'(REQ_TICK) + 1, 7)), 7'($urandom),
                  {$urandom, $urandom}, 1'b0);
      end else if (roll < 10) begin
        queue_tick();
      end else begin
        req = 3'($urandom_range(0, int'(REQ_RUN)));
        queue_cmd(req, pick_count(), {$urandom, $urandom},
                  first_seq || $urandom_range(0, 79) == 0);
        first_seq = 1'b0;
        while (seq_kind != KIND_IDLE) begin
          if ($urandom_range(0, 15) == 0)
            queue_cmd(3'($urandom_range(0, int'(REQ_RUN))), 7'($urandom),
                      {$urandom, $urandom}, 1'b0);
          queue_tick();
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || cmd_valid || pin_results_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d result beats: %0d TCK cycles, %0d commands finished, %0d rejected",
             n_checked, n_tck, n_done, n_rej);
    if (errors == 0) begin
      $display("jtag_scan_sequencer_top verification clean");
    end else begin
      $display("jtag_scan_sequencer_top verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("jtag_scan_sequencer_top verification failed");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
rtl/jss_pkg.sv
rtl/jss_in_reg.sv
rtl/jss_core.sv
rtl/jss_out_reg.sv
rtl/jtag_scan_sequencer_top.sv
tb/testbench.sv
